[rtl/efc_pkg.sv]
// Shared types and the ECC200 symbol size table for the finder classifier.
package efc_pkg;

  localparam int DIM_W     = 8;   // symbol size and module position width
  localparam int SPAN_W    = 5;   // region span (data region + 2), at most 26
  localparam int MULT_W    = 3;   // region boundaries below a position, at most 5
  localparam int MAX_MULT  = 5;
  localparam int SIZE_COUNT = 30;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [SPAN_W-1:0] reg_rows;
    logic [SPAN_W-1:0] reg_cols;
  } size_entry_t;

  // Lookup result handed from the size table to the pipeline.
  typedef struct packed {
    logic              legal;
    logic [SPAN_W-1:0] span_r;
    logic [SPAN_W-1:0] span_c;
  } size_info_t;

  localparam size_entry_t SIZE_TABLE [SIZE_COUNT] = '{
    '{8'd10,  8'd10,  5'd8,  5'd8 }, '{8'd12,  8'd12,  5'd10, 5'd10},
    '{8'd14,  8'd14,  5'd12, 5'd12}, '{8'd16,  8'd16,  5'd14, 5'd14},
    '{8'd18,  8'd18,  5'd16, 5'd16}, '{8'd20,  8'd20,  5'd18, 5'd18},
    '{8'd22,  8'd22,  5'd20, 5'd20}, '{8'd24,  8'd24,  5'd22, 5'd22},
    '{8'd26,  8'd26,  5'd24, 5'd24}, '{8'd32,  8'd32,  5'd14, 5'd14},
    '{8'd36,  8'd36,  5'd16, 5'd16}, '{8'd40,  8'd40,  5'd18, 5'd18},
    '{8'd44,  8'd44,  5'd20, 5'd20}, '{8'd48,  8'd48,  5'd22, 5'd22},
    '{8'd52,  8'd52,  5'd24, 5'd24}, '{8'd64,  8'd64,  5'd14, 5'd14},
    '{8'd72,  8'd72,  5'd16, 5'd16}, '{8'd80,  8'd80,  5'd18, 5'd18},
    '{8'd88,  8'd88,  5'd20, 5'd20}, '{8'd96,  8'd96,  5'd22, 5'd22},
    '{8'd104, 8'd104, 5'd24, 5'd24}, '{8'd120, 8'd120, 5'd18, 5'd18},
    '{8'd132, 8'd132, 5'd20, 5'd20}, '{8'd144, 8'd144, 5'd22, 5'd22},
    '{8'd8,   8'd18,  5'd6,  5'd16}, '{8'd8,   8'd32,  5'd6,  5'd14},
    '{8'd12,  8'd26,  5'd10, 5'd24}, '{8'd12,  8'd36,  5'd10, 5'd16},
    '{8'd16,  8'd36,  5'd14, 5'd16}, '{8'd16,  8'd48,  5'd14, 5'd22}
  };

endpackage

[rtl/ecc200_finder_module_classifier.sv]
// Top level: three-stage ECC200 finder/alignment pattern module classifier.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+------------------------------
//  in      | in_valid/in_ready, in_module_row/column | one module position per beat
//  out     | out_valid/out_ready, out_is_finder,     | one classification per beat
//          | out_expected_black, out_size_legal      |
//  cfg     | cfg_wr_en, cfg_index, cfg_wr_data       | register write, no wait
//
// Input beats pass through the stage 1, 2 and 3 registers to output valid; one
// beat per cycle sustained while out_ready is high. Stage 1 does the size-table
// match and bounds check, stage 2 counts region boundaries below the position,
// stage 3 forms the local position and classifies it into the output register.
// Synchronous active-low reset clears the stage valids and loads 10x10;
// in_ready stays low while reset is held.
// A stall at out_ready freezes every full stage behind it; empty stages still fill.
module ecc200_finder_module_classifier (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [efc_pkg::DIM_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [efc_pkg::DIM_W-1:0] in_module_row,
  input  logic [efc_pkg::DIM_W-1:0] in_module_column,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_is_finder,
  output logic                      out_expected_black,
  output logic                      out_size_legal
);
  import efc_pkg::*;

  localparam logic REG_SYMBOL_ROWS    = 1'b0;
  localparam logic REG_SYMBOL_COLUMNS = 1'b1;
  localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(10);

  // configuration
  logic [DIM_W-1:0] sym_rows_r, sym_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_rows_r <= SIZE_RESET;
      sym_cols_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYMBOL_ROWS:    sym_rows_r <= cfg_wr_data;
        REG_SYMBOL_COLUMNS: sym_cols_r <= cfg_wr_data;
        default:            ;
      endcase
    end
  end

  size_info_t size_info;

  efc_size_lut u_lut (
    .rows (sym_rows_r),
    .cols (sym_cols_r),
    .info (size_info)
  );

  // stage enables: a stage loads when it is empty or its beat moves on
  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1 && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: size match and bounds
  // Every legal size is a whole number of regions, so no divisibility check.
  logic [DIM_W-1:0]  s1_row_r, s1_col_r;
  logic              s1_legal_r, s1_ok_r;
  logic [SPAN_W-1:0] s1_span_r_r, s1_span_c_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_row_r    <= in_module_row;
      s1_col_r    <= in_module_column;
      s1_legal_r  <= size_info.legal;
      s1_ok_r     <= size_info.legal && (in_module_row < sym_rows_r)
                     && (in_module_column < sym_cols_r);
      s1_span_r_r <= size_info.span_r;
      s1_span_c_r <= size_info.span_c;
    end
  end

  // stage 2: region index = number of span multiples not above the position
  // (at most five, since a symbol has at most six regions per side)
  logic [MULT_W-1:0] k_row_nxt, k_col_nxt;

  always_comb begin
    k_row_nxt = '0;
    k_col_nxt = '0;
    for (int m = 1; m <= MAX_MULT; m++) begin
      if (DIM_W'(m) * DIM_W'(s1_span_r_r) <= s1_row_r) k_row_nxt = k_row_nxt + MULT_W'(1);
      if (DIM_W'(m) * DIM_W'(s1_span_c_r) <= s1_col_r) k_col_nxt = k_col_nxt + MULT_W'(1);
    end
  end

  logic [DIM_W-1:0]  s2_row_r, s2_col_r;
  logic              s2_legal_r, s2_ok_r;
  logic [SPAN_W-1:0] s2_span_r_r, s2_span_c_r;
  logic [MULT_W-1:0] s2_k_row_r, s2_k_col_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_row_r    <= s1_row_r;
      s2_col_r    <= s1_col_r;
      s2_legal_r  <= s1_legal_r;
      s2_ok_r     <= s1_ok_r;
      s2_span_r_r <= s1_span_r_r;
      s2_span_c_r <= s1_span_c_r;
      s2_k_row_r  <= k_row_nxt;
      s2_k_col_r  <= k_col_nxt;
    end
  end

  // stage 3: local position within the region, then border classification
  logic [DIM_W-1:0]  base_row, base_col;
  logic [SPAN_W-1:0] lr, lc;
  logic              finder_nxt, black_nxt;

  always_comb begin
    base_row   = DIM_W'(s2_k_row_r) * DIM_W'(s2_span_r_r);
    base_col   = DIM_W'(s2_k_col_r) * DIM_W'(s2_span_c_r);
    lr         = SPAN_W'(s2_row_r - base_row);
    lc         = SPAN_W'(s2_col_r - base_col);
    finder_nxt = 1'b0;
    black_nxt  = 1'b0;
    if (s2_ok_r) begin
      if (lc == '0 || lr == s2_span_r_r - SPAN_W'(1)) begin
        // solid left column / bottom row
        finder_nxt = 1'b1;
        black_nxt  = 1'b1;
      end else if (lr == '0) begin
        // clock track on top row: dark on even columns
        finder_nxt = 1'b1;
        black_nxt  = !lc[0];
      end else if (lc == s2_span_c_r - SPAN_W'(1)) begin
        // clock track on right column: dark on odd rows
        finder_nxt = 1'b1;
        black_nxt  = lr[0];
      end
    end
  end

  logic finder_r, black_r, legal_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      finder_r <= finder_nxt;
      black_r  <= black_nxt;
      legal_r  <= s2_legal_r;
    end
  end

  assign out_valid          = v3_r;
  assign out_is_finder      = finder_r;
  assign out_expected_black = black_r;
  assign out_size_legal     = legal_r;

endmodule

[rtl/efc_size_lut.sv]
// Symbol size table match: legal flag and region spans for the configured size.
module efc_size_lut (
  input  logic [efc_pkg::DIM_W-1:0] rows,
  input  logic [efc_pkg::DIM_W-1:0] cols,
  output efc_pkg::size_info_t       info
);
  import efc_pkg::*;

  logic [SIZE_COUNT-1:0] hit;

  // Entries are unique, so at most one hit; spans are OR-combined.
  always_comb begin
    info = '0;
    for (int i = 0; i < SIZE_COUNT; i++) begin
      hit[i] = (SIZE_TABLE[i].rows == rows) && (SIZE_TABLE[i].cols == cols);
      if (hit[i]) begin
        info.span_r = info.span_r | (SIZE_TABLE[i].reg_rows + SPAN_W'(2));
        info.span_c = info.span_c | (SIZE_TABLE[i].reg_cols + SPAN_W'(2));
      end
    end
    info.legal = |hit;
  end

endmodule
